@@ sv/text_console_cursor_scroll_assert.svh @@
// Assertion macros for the text console block.
// Used by the top level; depends on nothing else.
`ifndef TEXT_CONSOLE_CURSOR_SCROLL_ASSERT_SVH
`define TEXT_CONSOLE_CURSOR_SCROLL_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define TCC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("tcc assertion failed");

// next-cycle implication, disabled while reset is low
`define TCC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("tcc assertion failed");

`endif

@@ sv/tcc_pkg.sv @@
// Shared types and constants for the text console block.
// No dependencies.
package tcc_pkg;

    localparam logic       OP_PUT       = 1'b0;
    localparam logic       OP_READ      = 1'b1;

    localparam logic [7:0] CH_BACKSPACE = 8'd8;
    localparam logic [7:0] CH_NEWLINE   = 8'd10;
    localparam logic [7:0] CH_SPACE     = 8'd32;
    localparam logic [7:0] RESET_ATTR   = 8'h07;

    typedef struct packed {
        logic [7:0]  cell_char;
        logic [7:0]  cell_attr;
        logic [4:0]  cursor_row;
        logic [6:0]  cursor_col;
        logic [10:0] cursor_offset;
    } t_result;

endpackage

@@ sv/tcc_in_if.sv @@
// Input item channel of the text console block.
// No dependencies.
interface tcc_in_if;
    logic       valid;
    logic       ready;
    logic       operation;
    logic [7:0] char_code;
    logic [4:0] read_row;
    logic [6:0] read_col;

    modport source (output valid, operation, char_code, read_row, read_col, input ready);
    modport sink   (input valid, operation, char_code, read_row, read_col, output ready);
endinterface

@@ sv/tcc_out_if.sv @@
// Result item channel of the text console block.
// No dependencies.
interface tcc_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  cell_char;
    logic [7:0]  cell_attr;
    logic [4:0]  cursor_row;
    logic [6:0]  cursor_col;
    logic [10:0] cursor_offset;

    modport source (output valid, cell_char, cell_attr, cursor_row, cursor_col,
                    cursor_offset, input ready);
    modport sink   (input valid, cell_char, cell_attr, cursor_row, cursor_col,
                    cursor_offset, output ready);
endinterface

@@ sv/tcc_cfg_if.sv @@
// Configuration write channel: the text color attribute.
// No dependencies.
interface tcc_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_color;

    modport source (output valid, text_color, input ready);
    modport sink   (input valid, text_color, output ready);
endinterface

@@ sv/tcc_screen_ram.sv @@
// Screen cell memory: one shared port, synchronous write, registered read.
// No dependencies.
module tcc_screen_ram #(
    parameter int DEPTH = 2000
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [15:0]              i_wdata,
    output logic [15:0]              o_rdata
);

    logic [15:0] r_mem [DEPTH];
    logic [15:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ sv/tcc_ctrl.sv @@
// Cursor sequencer: clears the screen after reset, runs each item against
// the screen memory and scrolls by rotating the top row. Uses tcc_pkg,
// tcc_in_if and tcc_screen_ram.
module tcc_ctrl #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    tcc_in_if.sink          i_in,
    input  logic [7:0]      i_text_color,
    input  logic            i_res_take,
    output logic            o_res_valid,
    output tcc_pkg::t_result o_res
);

    localparam int CELLS = ROWS * COLUMNS;
    localparam int AW    = $clog2(CELLS);
    localparam int RW    = $clog2(ROWS);
    localparam int CW    = $clog2(COLUMNS);

    localparam logic [RW-1:0] LAST_ROW  = RW'(ROWS - 1);
    localparam logic [CW-1:0] LAST_COL  = CW'(COLUMNS - 1);
    localparam logic [RW:0]   ROWS_W    = (RW + 1)'(ROWS);
    localparam logic [AW-1:0] LAST_CELL = AW'(CELLS - 1);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC,
        S_WRITE,
        S_BLANK,
        S_RDWAIT,
        S_DONE
    } t_state;

    t_state        r_state;
    logic [AW-1:0] r_clr;
    logic [RW-1:0] r_row;
    logic [CW-1:0] r_col;
    logic [RW-1:0] r_top;
    logic [CW-1:0] r_bcol;
    logic          r_op;
    logic [7:0]    r_ch;
    logic [4:0]    r_rr;
    logic [6:0]    r_rc;
    logic [7:0]    r_rd_char;
    logic [7:0]    r_rd_attr;

    logic          is_read;
    logic          is_nl;
    logic          is_bs;
    logic          rd_in_range;
    logic [RW-1:0] rd_row;
    logic [CW-1:0] rd_col;
    logic [RW-1:0] row_sel;
    logic [CW-1:0] col_sel;
    logic [RW:0]   phys_sum;
    logic [RW:0]   phys_row;
    logic [RW-1:0] top_inc;
    logic [AW-1:0] cell_addr;
    logic [AW-1:0] ram_addr;
    logic          ram_we;
    logic          ram_re;
    logic [15:0]   ram_wdata;
    logic [15:0]   ram_rdata;

    logic [AW-1:0]    cur_off;
    logic [AW+10:0]   cur_off_w;
    logic [RW+4:0]    cur_row_w;
    logic [CW+6:0]    cur_col_w;

    assign is_read     = (r_op == tcc_pkg::OP_READ);
    assign is_nl       = (r_ch == tcc_pkg::CH_NEWLINE);
    assign is_bs       = (r_ch == tcc_pkg::CH_BACKSPACE);
    assign rd_in_range = (32'(r_rr) < ROWS) && (32'(r_rc) < COLUMNS);
    assign rd_row      = RW'(r_rr);
    assign rd_col      = CW'(r_rc);

    always_comb begin
        row_sel = r_row;
        col_sel = r_col;
        if (r_state == S_EXEC && is_read) begin
            row_sel = rd_row;
            col_sel = rd_col;
        end else if (r_state == S_BLANK) begin
            col_sel = r_bcol;
        end
    end

    // logical row to memory row: the screen top sits at r_top
    assign phys_sum  = {1'b0, row_sel} + {1'b0, r_top};
    assign phys_row  = (phys_sum >= ROWS_W) ? (phys_sum - ROWS_W) : phys_sum;
    assign cell_addr = AW'(phys_row) * AW'(COLUMNS) + AW'(col_sel);
    assign top_inc   = (r_top == LAST_ROW) ? '0 : r_top + 1'b1;

    always_comb begin
        ram_we    = 1'b0;
        ram_re    = 1'b0;
        ram_addr  = cell_addr;
        ram_wdata = {i_text_color, tcc_pkg::CH_SPACE};
        case (r_state)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_addr  = r_clr;
                ram_wdata = {tcc_pkg::RESET_ATTR, tcc_pkg::CH_SPACE};
            end
            S_EXEC: begin
                if (is_read) begin
                    ram_re = rd_in_range;
                end else if (!is_nl && !is_bs) begin
                    ram_we    = 1'b1;
                    ram_wdata = {i_text_color, r_ch};
                end
            end
            S_WRITE: ram_we = 1'b1;
            S_BLANK: ram_we = 1'b1;
            default: ;
        endcase
    end

    tcc_screen_ram #(
        .DEPTH (CELLS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_re    (ram_re),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_row   <= '0;
            r_col   <= '0;
            r_top   <= '0;
        end else begin
            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == LAST_CELL) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_op    <= i_in.operation;
                        r_ch    <= i_in.char_code;
                        r_rr    <= i_in.read_row;
                        r_rc    <= i_in.read_col;
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_rd_char <= '0;
                    r_rd_attr <= '0;
                    r_bcol    <= '0;
                    if (is_read) begin
                        r_state <= rd_in_range ? S_RDWAIT : S_DONE;
                    end else if (is_bs) begin
                        if (r_col != '0) begin
                            r_col <= r_col - 1'b1;
                        end else if (r_row != '0) begin
                            r_row <= r_row - 1'b1;
                            r_col <= LAST_COL;
                        end
                        r_state <= S_WRITE;
                    end else if (is_nl || r_col == LAST_COL) begin
                        r_col <= '0;
                        if (r_row == LAST_ROW) begin
                            // scroll: old top row becomes the blank bottom row
                            r_top   <= top_inc;
                            r_state <= S_BLANK;
                        end else begin
                            r_row   <= r_row + 1'b1;
                            r_state <= S_DONE;
                        end
                    end else begin
                        r_col   <= r_col + 1'b1;
                        r_state <= S_DONE;
                    end
                end
                S_WRITE: r_state <= S_DONE;
                S_BLANK: begin
                    r_bcol <= r_bcol + 1'b1;
                    if (r_bcol == LAST_COL) begin
                        r_state <= S_DONE;
                    end
                end
                S_RDWAIT: begin
                    r_rd_char <= ram_rdata[7:0];
                    r_rd_attr <= ram_rdata[15:8];
                    r_state   <= S_DONE;
                end
                S_DONE: begin
                    if (i_res_take) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign i_in.ready  = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_DONE);

    assign cur_off   = AW'(r_row) * AW'(COLUMNS) + AW'(r_col);
    assign cur_off_w = (AW + 11)'(cur_off);
    assign cur_row_w = (RW + 5)'(r_row);
    assign cur_col_w = (CW + 7)'(r_col);

    always_comb begin
        o_res.cell_char     = r_rd_char;
        o_res.cell_attr     = r_rd_attr;
        o_res.cursor_row    = cur_row_w[4:0];
        o_res.cursor_col    = cur_col_w[6:0];
        o_res.cursor_offset = cur_off_w[10:0];
    end

endmodule

@@ sv/text_console_cursor_scroll.sv @@
// Text console: a plain character, newline or out-of-range read passes S_IDLE, S_EXEC and
// S_DONE; a backspace adds S_WRITE, an in-range read S_RDWAIT, a scroll S_BLANK (bottom row blanked).
// The result register loads as the item leaves S_DONE; one memory access a cycle.
// After reset a clearing pass fills the screen with spaces in color 0x07; no item is
// taken meanwhile. Color resets to 0x07.
`include "text_console_cursor_scroll_assert.svh"

module text_console_cursor_scroll #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tcc_in_if.sink     i_in,
    tcc_cfg_if.sink    i_cfg,
    tcc_out_if.source  o_out
);

    logic             r_out_valid;
    tcc_pkg::t_result r_out;
    logic [7:0]       r_text_color;

    logic             res_valid;
    logic             res_take;
    tcc_pkg::t_result res;

    assign res_take = !r_out_valid || o_out.ready;

    tcc_ctrl #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .i_text_color (r_text_color),
        .i_res_take   (res_take),
        .o_res_valid  (res_valid),
        .o_res        (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_text_color <= tcc_pkg::RESET_ATTR;
        end else begin
            if (i_cfg.valid) begin
                r_text_color <= i_cfg.text_color;
            end
            if (res_take) begin
                r_out_valid <= res_valid;
                if (res_valid) begin
                    r_out <= res;
                end
            end
        end
    end

    assign i_cfg.ready         = 1'b1;
    assign o_out.valid         = r_out_valid;
    assign o_out.cell_char     = r_out.cell_char;
    assign o_out.cell_attr     = r_out.cell_attr;
    assign o_out.cursor_row    = r_out.cursor_row;
    assign o_out.cursor_col    = r_out.cursor_col;
    assign o_out.cursor_offset = r_out.cursor_offset;

    `TCC_ASSERT_NOW(a_cursor_in_screen, i_clk, i_rst_n, o_out.valid,
        (32'(o_out.cursor_row) < ROWS) && (32'(o_out.cursor_col) < COLUMNS))
    `TCC_ASSERT_NEXT(a_one_item_at_a_time, i_clk, i_rst_n, i_in.valid && i_in.ready,
        !i_in.ready)
    `TCC_ASSERT_NEXT(a_result_handoff, i_clk, i_rst_n, res_valid && res_take,
        o_out.valid && !res_valid)

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for text_console_cursor_scroll: keeps a shadow screen and cursor,
// drives directed and burst-shaped random items, and checks every result in order.
// Depends on tcc_pkg and the tcc_in_if, tcc_out_if and tcc_cfg_if interfaces.
`timescale 1ns / 1ps

module tb_top;

    localparam int COLS           = 80;
    localparam int ROWS           = 25;
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 8000;
    localparam int ITEMS_PER_PASS = 610;

    typedef struct packed {
        logic             op;
        logic [7:0]       ch;
        logic [4:0]       rr;
        logic [6:0]       rc;
        logic             typed;
        tcc_pkg::t_result want;
    } t_vector;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    tcc_in_if  in_ch ();
    tcc_out_if out_ch ();
    tcc_cfg_if cfg_ch ();

    text_console_cursor_scroll #(
        .COLUMNS (COLS),
        .ROWS    (ROWS)
    ) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .i_cfg   (cfg_ch),
        .o_out   (out_ch)
    );

    always #5 i_clk = ~i_clk;

    // shadow of the console state
    logic [15:0] screen_mirror [ROWS*COLS];
    int          cur_row;
    int          cur_col;
    logic [7:0]  text_color_now;

    tcc_pkg::t_result results_due [$];
    t_vector          directed_table [$];
    int               errors;
    int               src_idle_pct;
    int               snk_idle_pct;
    logic             hold_req;
    logic             hold_done;
    int               hold_left;
    int               idle_cycles = 0;

    function automatic void next_line();
        cur_row++;
        if (cur_row >= ROWS) begin
            for (int i = 0; i < (ROWS - 1) * COLS; i++)
                screen_mirror[i] = screen_mirror[i + COLS];
            for (int i = (ROWS - 1) * COLS; i < ROWS * COLS; i++)
                screen_mirror[i] = {text_color_now, tcc_pkg::CH_SPACE};
            cur_row = ROWS - 1;
        end
    endfunction

    function automatic tcc_pkg::t_result console_step_result(input logic op,
                                                             input logic [7:0] ch,
                                                             input logic [4:0] rr,
                                                             input logic [6:0] rc);
        tcc_pkg::t_result r;
        int               idx;
        r = '0;
        if (op == tcc_pkg::OP_READ) begin
            if (rr < ROWS && rc < COLS) begin
                idx = int'(rr) * COLS + int'(rc);
                r.cell_char = screen_mirror[idx][7:0];
                r.cell_attr = screen_mirror[idx][15:8];
            end
        end else if (ch == tcc_pkg::CH_NEWLINE) begin
            cur_col = 0;
            next_line();
        end else if (ch == tcc_pkg::CH_BACKSPACE) begin
            if (cur_col > 0) begin
                cur_col--;
            end else if (cur_row > 0) begin
                cur_row--;
                cur_col = COLS - 1;
            end
            screen_mirror[cur_row * COLS + cur_col] = {text_color_now, tcc_pkg::CH_SPACE};
        end else begin
            screen_mirror[cur_row * COLS + cur_col] = {text_color_now, ch};
            cur_col++;
            if (cur_col >= COLS) begin
                cur_col = 0;
                next_line();
            end
        end
        r.cursor_row    = 5'(cur_row);
        r.cursor_col    = 7'(cur_col);
        r.cursor_offset = 11'(cur_row * COLS + cur_col);
        return r;
    endfunction

    function automatic void add_vec(input logic op, input logic [7:0] ch, input logic [4:0] rr,
                                    input logic [6:0] rc, input logic typed,
                                    input tcc_pkg::t_result want);
        t_vector v;
        v.op    = op;
        v.ch    = ch;
        v.rr    = rr;
        v.rc    = rc;
        v.typed = typed;
        v.want  = want;
        directed_table.push_back(v);
    endfunction

    task automatic send_item(input t_vector v);
        tcc_pkg::t_result got;
        while ($urandom_range(99) < src_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.operation <= v.op;
        in_ch.char_code <= v.ch;
        in_ch.read_row  <= v.rr;
        in_ch.read_col  <= v.rc;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
        got = console_step_result(v.op, v.ch, v.rr, v.rc);
        results_due.push_back(v.typed ? v.want : got);
    endtask

    task automatic write_text_color(input logic [7:0] c);
        cfg_ch.valid      <= 1'b1;
        cfg_ch.text_color <= c;
        do @(posedge i_clk); while (cfg_ch.ready !== 1'b1);
        text_color_now = c;
        cfg_ch.valid <= 1'b0;
    endtask

    // wait for every result, then let a bottom-row blank finish
    task automatic drain_console();
        in_ch.valid <= 1'b0;
        while (results_due.size() != 0) @(posedge i_clk);
        repeat (COLS + 20) @(posedge i_clk);
    endtask

    task automatic run_random_pass(input int n_items);
        t_vector v;
        int      sent;
        int      kind;
        int      len;
        sent = 0;
        while (sent < n_items) begin
            kind = $urandom_range(99);
            if (kind < 35) len = $urandom_range(100, 60);      // long line, wraps the column
            else if (kind < 50) len = $urandom_range(6, 1);    // newline run, scrolls
            else if (kind < 65) len = $urandom_range(90, 1);   // backspace run
            else if (kind < 85) len = $urandom_range(8, 1);    // reads in range
            else len = $urandom_range(10, 1);                  // noise
            for (int k = 0; k < len && sent < n_items; k++) begin
                v       = '0;
                v.rr    = 5'($urandom_range(31));
                v.rc    = 7'($urandom_range(127));
                v.ch    = 8'($urandom_range(255));
                v.op    = tcc_pkg::OP_PUT;
                if (kind < 35) begin
                    while (v.ch == tcc_pkg::CH_NEWLINE || v.ch == tcc_pkg::CH_BACKSPACE)
                        v.ch = 8'($urandom_range(255));
                end else if (kind < 50) begin
                    v.ch = tcc_pkg::CH_NEWLINE;
                end else if (kind < 65) begin
                    v.ch = tcc_pkg::CH_BACKSPACE;
                end else if (kind < 85) begin
                    v.op = tcc_pkg::OP_READ;
                    v.rr = 5'($urandom_range(ROWS - 1));
                    v.rc = 7'($urandom_range(COLS - 1));
                end else begin
                    v.op = 1'($urandom_range(1));
                end
                send_item(v);
                sent++;
            end
        end
    endtask

    // receiver side, with one long hold-off on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            hold_left    <= 0;
            hold_done    <= 1'b0;
        end else if (hold_left > 0) begin
            out_ch.ready <= 1'b0;
            hold_left    <= hold_left - 1;
        end else if (hold_req && !hold_done) begin
            out_ch.ready <= 1'b0;
            hold_left    <= HOLD_CYCLES;
            hold_done    <= 1'b1;
        end else begin
            out_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    always @(posedge i_clk) begin : result_check
        tcc_pkg::t_result want;
        tcc_pkg::t_result got;
        if (i_rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
            got = {out_ch.cell_char, out_ch.cell_attr, out_ch.cursor_row, out_ch.cursor_col,
                   out_ch.cursor_offset};
            if (results_due.size() == 0) begin
                $display("%0t: unexpected result char=%h attr=%h row=%0d col=%0d off=%0d",
                         $time, got.cell_char, got.cell_attr, got.cursor_row, got.cursor_col,
                         got.cursor_offset);
                errors++;
            end else begin
                want = results_due.pop_front();
                if (got !== want) begin
                    $display("%0t: mismatch expected char=%h attr=%h row=%0d col=%0d off=%0d",
                             $time, want.cell_char, want.cell_attr, want.cursor_row,
                             want.cursor_col, want.cursor_offset);
                    $display("%0t:          actual   char=%h attr=%h row=%0d col=%0d off=%0d",
                             $time, got.cell_char, got.cell_attr, got.cursor_row,
                             got.cursor_col, got.cursor_offset);
                    errors++;
                end
            end
        end
    end

    // ends the run when no handshake happens for too long (covers the clearing pass)
    always @(posedge i_clk) begin
        if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1)
            || (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
            || (cfg_ch.valid === 1'b1 && cfg_ch.ready === 1'b1)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, idle_cycles);
            $display("Regression FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        in_ch.valid       <= 1'b0;
        in_ch.operation   <= tcc_pkg::OP_PUT;
        in_ch.char_code   <= 8'd0;
        in_ch.read_row    <= 5'd0;
        in_ch.read_col    <= 7'd0;
        cfg_ch.valid      <= 1'b0;
        cfg_ch.text_color <= 8'd0;
        hold_req          <= 1'b0;
        src_idle_pct      <= 38;
        snk_idle_pct      <= 56;
        errors         = 0;
        cur_row        = 0;
        cur_col        = 0;
        text_color_now = tcc_pkg::RESET_ATTR;
        for (int i = 0; i < ROWS * COLS; i++)
            screen_mirror[i] = {tcc_pkg::RESET_ATTR, tcc_pkg::CH_SPACE};

        //      op, char, row, col, typed,
        //      expected {char, attr, row, col, off}
        add_vec(tcc_pkg::OP_READ, 8'd0, 5'd0, 7'd0, 1'b1,
                {tcc_pkg::CH_SPACE, tcc_pkg::RESET_ATTR, 5'd0, 7'd0, 11'd0});
        add_vec(tcc_pkg::OP_READ, 8'd0, 5'd24, 7'd79, 1'b1,
                {tcc_pkg::CH_SPACE, tcc_pkg::RESET_ATTR, 5'd0, 7'd0, 11'd0});
        add_vec(tcc_pkg::OP_READ, 8'hFF, 5'd31, 7'd127, 1'b1,
                {8'd0, 8'd0, 5'd0, 7'd0, 11'd0});
        add_vec(tcc_pkg::OP_READ, 8'd0, 5'd25, 7'd0, 1'b1,
                {8'd0, 8'd0, 5'd0, 7'd0, 11'd0});
        add_vec(tcc_pkg::OP_READ, 8'd0, 5'd0, 7'd80, 1'b1,
                {8'd0, 8'd0, 5'd0, 7'd0, 11'd0});
        add_vec(tcc_pkg::OP_PUT, tcc_pkg::CH_BACKSPACE, 5'd0, 7'd0, 1'b1,
                {8'd0, 8'd0, 5'd0, 7'd0, 11'd0});
        add_vec(tcc_pkg::OP_READ, 8'd0, 5'd0, 7'd0, 1'b1,
                {tcc_pkg::CH_SPACE, tcc_pkg::RESET_ATTR, 5'd0, 7'd0, 11'd0});
        add_vec(tcc_pkg::OP_PUT, 8'h41, 5'd31, 7'd127, 1'b1,
                {8'd0, 8'd0, 5'd0, 7'd1, 11'd1});
        add_vec(tcc_pkg::OP_PUT,  8'h00,                 5'd0,  7'd0,   1'b0, '0);
        add_vec(tcc_pkg::OP_PUT,  8'hFF,                 5'd17, 7'd42,  1'b0, '0);
        add_vec(tcc_pkg::OP_READ, 8'd0,                  5'd0,  7'd0,   1'b0, '0);
        add_vec(tcc_pkg::OP_READ, 8'd0,                  5'd0,  7'd2,   1'b0, '0);
        add_vec(tcc_pkg::OP_PUT,  tcc_pkg::CH_BACKSPACE, 5'd0,  7'd0,   1'b0, '0);
        add_vec(tcc_pkg::OP_READ, 8'd0,                  5'd0,  7'd2,   1'b0, '0);
        add_vec(tcc_pkg::OP_PUT,  tcc_pkg::CH_NEWLINE,   5'd31, 7'd127, 1'b0, '0);
        add_vec(tcc_pkg::OP_PUT,  tcc_pkg::CH_BACKSPACE, 5'd0,  7'd0,   1'b0, '0);
        add_vec(tcc_pkg::OP_READ, 8'd0,                  5'd0,  7'd79,  1'b0, '0);
        add_vec(tcc_pkg::OP_PUT,  8'h7F,                 5'd0,  7'd0,   1'b0, '0);
        add_vec(tcc_pkg::OP_PUT,  tcc_pkg::CH_NEWLINE,   5'd12, 7'd55,  1'b0, '0);
        add_vec(tcc_pkg::OP_READ, tcc_pkg::CH_BACKSPACE, 5'd0,  7'd1,   1'b0, '0);
        add_vec(tcc_pkg::OP_READ, tcc_pkg::CH_NEWLINE,   5'd1,  7'd0,   1'b0, '0);

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_table[i])
            send_item(directed_table[i]);
        drain_console();

        write_text_color(8'hFF);
        run_random_pass(ITEMS_PER_PASS);
        drain_console();

        src_idle_pct <= 56;
        snk_idle_pct <= 38;
        write_text_color(8'h00);
        run_random_pass(ITEMS_PER_PASS);
        drain_console();

        src_idle_pct <= 0;
        snk_idle_pct <= 0;
        write_text_color(8'($urandom_range(254, 1)));
        hold_req <= 1'b1;
        run_random_pass(ITEMS_PER_PASS);
        drain_console();

        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
